// ----- design/sfs_pkg.sv -----
package sfs_pkg;

    // Field and datapath widths
    localparam int SFS_DELTA_BITS    = 20;
    localparam int SFS_IN_DATA_BITS  = 24;
    localparam int SFS_OUT_DATA_BITS = 88;
    localparam int SFS_OUT_USER_BITS = 2;
    localparam int SFS_CFG_ADDR_BITS = 3;
    localparam int SFS_CFG_DATA_BITS = 24;
    localparam int SFS_CNT_BITS      = 5;
    localparam int SFS_DUR_BITS      = 24;
    localparam int SFS_GEOM_BITS     = 13;
    localparam int SFS_IDX_BITS      = 8;
    localparam int SFS_FRAMES_BITS   = 9;
    localparam int SFS_CELL_BITS     = 4;
    localparam int SFS_REM_BITS      = 32;
    localparam int SFS_PC_BITS       = 5;
    localparam int SFS_DEF_TIME_BITS = 40;

    // Cap on the number of frames in one animation
    localparam logic [SFS_FRAMES_BITS-1:0] SFS_MAX_FRAMES = 9'd256;

    // Register limits and reset values
    localparam logic [SFS_CNT_BITS-1:0]  SFS_CNT_MAX    = 5'd16;
    localparam logic [SFS_GEOM_BITS-1:0] SFS_SHEET_MAX  = 13'd4096;
    localparam logic [SFS_CNT_BITS-1:0]  SFS_RST_ACROSS = 5'd1;
    localparam logic [SFS_CNT_BITS-1:0]  SFS_RST_DOWN   = 5'd1;
    localparam logic [SFS_DUR_BITS-1:0]  SFS_RST_DUR    = 24'd100000;
    localparam logic [SFS_GEOM_BITS-1:0] SFS_RST_SHEET  = 13'd64;

    // Request kinds carried on tuser
    localparam logic SFS_REQ_TICK    = 1'b0;
    localparam logic SFS_REQ_RESTART = 1'b1;

    // Configuration register indexes
    typedef enum logic [SFS_CFG_ADDR_BITS-1:0] {
        CFG_ACROSS   = 3'd0,
        CFG_DOWN     = 3'd1,
        CFG_DURATION = 3'd2,
        CFG_SHEET_W  = 3'd3,
        CFG_SHEET_H  = 3'd4,
        CFG_TTB      = 3'd5,
        CFG_LOOPING  = 3'd6,
        CFG_HOLD     = 3'd7
    } cfg_idx_t;

    // Micro-operations
    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_ACCEPT    = 4'd1,
        OP_RESTART   = 4'd2,
        OP_TOTAL_SUM = 4'd3,
        OP_SATADD    = 4'd4,
        OP_DIV_START = 4'd5,
        OP_DIV_WAIT  = 4'd6,
        OP_UPDATE    = 4'd7,
        OP_CLAMP     = 4'd8,
        OP_MUL       = 4'd9,
        OP_EMIT      = 4'd10
    } op_t;

    // Divider operand and result selection
    typedef enum logic [2:0] {
        DSEL_MOD = 3'd0,
        DSEL_IDX = 3'd1,
        DSEL_FW  = 3'd2,
        DSEL_FH  = 3'd3,
        DSEL_CR  = 3'd4
    } dsel_t;

    // Jump conditions
    typedef enum logic [1:0] {
        COND_NEVER   = 2'd0,
        COND_ALWAYS  = 2'd1,
        COND_RESTART = 2'd2,
        COND_STOPPED = 2'd3
    } cond_t;

    typedef struct packed {
        op_t                    op;
        dsel_t                  dsel;
        cond_t                  cond;
        logic [SFS_PC_BITS-1:0] target;
    } ucode_t;

    // Jump targets
    localparam logic [SFS_PC_BITS-1:0] ST_IDLE    = 5'd0;
    localparam logic [SFS_PC_BITS-1:0] ST_RESTART = 5'd9;
    localparam logic [SFS_PC_BITS-1:0] ST_SATADD  = 5'd10;
    localparam logic [SFS_PC_BITS-1:0] ST_GEOM    = 5'd11;

    // Control store
    function automatic ucode_t sfs_ucode(input logic [SFS_PC_BITS-1:0] pc);
        ucode_t w;
        w = '{op: OP_NOP, dsel: DSEL_MOD, cond: COND_ALWAYS, target: ST_IDLE};
        case (pc)
            5'd0:  w = '{op: OP_ACCEPT,    dsel: DSEL_MOD, cond: COND_NEVER,   target: ST_IDLE};
            5'd1:  w = '{op: OP_NOP,       dsel: DSEL_MOD, cond: COND_RESTART, target: ST_RESTART};
            5'd2:  w = '{op: OP_NOP,       dsel: DSEL_MOD, cond: COND_STOPPED, target: ST_SATADD};
            5'd3:  w = '{op: OP_TOTAL_SUM, dsel: DSEL_MOD, cond: COND_NEVER,   target: ST_IDLE};
            5'd4:  w = '{op: OP_DIV_START, dsel: DSEL_MOD, cond: COND_NEVER,   target: ST_IDLE};
            5'd5:  w = '{op: OP_DIV_WAIT,  dsel: DSEL_MOD, cond: COND_NEVER,   target: ST_IDLE};
            5'd6:  w = '{op: OP_DIV_START, dsel: DSEL_IDX, cond: COND_NEVER,   target: ST_IDLE};
            5'd7:  w = '{op: OP_DIV_WAIT,  dsel: DSEL_IDX, cond: COND_NEVER,   target: ST_IDLE};
            5'd8:  w = '{op: OP_UPDATE,    dsel: DSEL_MOD, cond: COND_ALWAYS,  target: ST_GEOM};
            5'd9:  w = '{op: OP_RESTART,   dsel: DSEL_MOD, cond: COND_ALWAYS,  target: ST_GEOM};
            5'd10: w = '{op: OP_SATADD,    dsel: DSEL_MOD, cond: COND_NEVER,   target: ST_IDLE};
            5'd11: w = '{op: OP_CLAMP,     dsel: DSEL_MOD, cond: COND_NEVER,   target: ST_IDLE};
            5'd12: w = '{op: OP_DIV_START, dsel: DSEL_FW,  cond: COND_NEVER,   target: ST_IDLE};
            5'd13: w = '{op: OP_DIV_WAIT,  dsel: DSEL_FW,  cond: COND_NEVER,   target: ST_IDLE};
            5'd14: w = '{op: OP_DIV_START, dsel: DSEL_FH,  cond: COND_NEVER,   target: ST_IDLE};
            5'd15: w = '{op: OP_DIV_WAIT,  dsel: DSEL_FH,  cond: COND_NEVER,   target: ST_IDLE};
            5'd16: w = '{op: OP_DIV_START, dsel: DSEL_CR,  cond: COND_NEVER,   target: ST_IDLE};
            5'd17: w = '{op: OP_DIV_WAIT,  dsel: DSEL_CR,  cond: COND_NEVER,   target: ST_IDLE};
            5'd18: w = '{op: OP_MUL,       dsel: DSEL_MOD, cond: COND_NEVER,   target: ST_IDLE};
            5'd19: w = '{op: OP_EMIT,      dsel: DSEL_MOD, cond: COND_ALWAYS,  target: ST_IDLE};
            default: w = '{op: OP_NOP, dsel: DSEL_MOD, cond: COND_ALWAYS, target: ST_IDLE};
        endcase
        return w;
    endfunction

    // Frame counts: 0 acts as 1, above 16 acts as 16
    function automatic logic [SFS_CNT_BITS-1:0] sfs_clamp_cnt(input logic [SFS_CNT_BITS-1:0] v);
        logic [SFS_CNT_BITS-1:0] r;
        r = v;
        if (v == '0) r = 5'd1;
        else if (v > SFS_CNT_MAX) r = SFS_CNT_MAX;
        return r;
    endfunction

    // Sheet sizes: 0 acts as 1, above 4096 acts as 4096
    function automatic logic [SFS_GEOM_BITS-1:0] sfs_clamp_sheet(
        input logic [SFS_GEOM_BITS-1:0] v
    );
        logic [SFS_GEOM_BITS-1:0] r;
        r = v;
        if (v == '0) r = 13'd1;
        else if (v > SFS_SHEET_MAX) r = SFS_SHEET_MAX;
        return r;
    endfunction

endpackage

// ----- design/sfs_divider.sv -----
module sfs_divider #(
    parameter int DW = sfs_pkg::SFS_DEF_TIME_BITS,
    parameter int CW = $clog2(DW + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [CW-1:0]                   count,
    input  logic [sfs_pkg::SFS_REM_BITS-1:0] rem_init,
    input  logic [DW-1:0]                   quo_init,
    input  logic [sfs_pkg::SFS_REM_BITS-1:0] divisor,
    output logic                            busy,
    output logic [sfs_pkg::SFS_REM_BITS-1:0] rem,
    output logic [DW-1:0]                   quo
);
    import sfs_pkg::*;

    localparam int RW = SFS_REM_BITS;

    logic [RW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [RW-1:0] div_reg, div_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;

    logic [RW:0]   shifted;
    logic [RW+1:0] diff;
    logic          take;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, div_reg};
    assign take    = ~diff[RW+1];

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = rem_init;
            quo_next  = quo_init;
            div_next  = divisor;
            cnt_next  = count;
            busy_next = (count != '0);
        end
        else if (busy_reg)
        begin
            rem_next  = take ? diff[RW-1:0] : shifted[RW-1:0];
            quo_next  = {quo_reg[DW-2:0], take};
            cnt_next  = cnt_reg - CW'(1);
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and result registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;
    assign quo  = quo_reg;

endmodule

// ----- design/sprite_frame_sequencer_core.sv -----
// Sprite-sheet frame sequencer, driven by a microcoded control store.
// The shared one-bit-per-cycle divider does the divisions (TIME_BITS steps for the wrap).
// Requests are handled one at a time; the next request is taken while a result waits.
// Reset (rst_n, asynchronous, active low): registers return to their defaults, the sprite
// is playing from frame 0 with zero elapsed time, and no result is pending.
module sprite_frame_sequencer_core #(
    parameter int TIME_BITS = sfs_pkg::SFS_DEF_TIME_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Requests
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [sfs_pkg::SFS_IN_DATA_BITS-1:0]   s_tdata,  // [19:0] time_delta
    input  logic                                   s_tuser,  // [0] req_type
    // Results
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [7:0] frame_index, [20:8] rect_left, [33:21] rect_bottom, [46:34] rect_right,
    // [59:47] rect_top, [72:60] frame_width, [85:73] frame_height
    output logic [sfs_pkg::SFS_OUT_DATA_BITS-1:0]  m_tdata,
    output logic [sfs_pkg::SFS_OUT_USER_BITS-1:0]  m_tuser,  // [0] playing, [1] end_event
    // Register writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sfs_pkg::SFS_CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [sfs_pkg::SFS_CFG_DATA_BITS-1:0]  cfg_data
);
    import sfs_pkg::*;

    localparam int CNT_W = $clog2(TIME_BITS + 1);
    localparam int RW    = SFS_REM_BITS;

    // Configuration registers
    logic [SFS_CNT_BITS-1:0]  across_reg, across_next;
    logic [SFS_CNT_BITS-1:0]  down_reg, down_next;
    logic [SFS_DUR_BITS-1:0]  dur_reg, dur_next;
    logic [SFS_GEOM_BITS-1:0] sw_reg, sw_next;
    logic [SFS_GEOM_BITS-1:0] sh_reg, sh_next;
    logic                     ttb_reg, ttb_next;
    logic                     loop_reg, loop_next;
    logic                     hold_reg, hold_next;

    // Animation state
    logic [TIME_BITS-1:0]     elapsed_reg, elapsed_next;
    logic [SFS_IDX_BITS-1:0]  shown_reg, shown_next;
    logic                     playing_reg, playing_next;
    logic                     holding_reg, holding_next;

    // Sequencer and datapath
    logic [SFS_PC_BITS-1:0]     pc_reg, pc_next;
    logic [SFS_FRAMES_BITS-1:0] frames_reg, frames_next;
    logic [RW-1:0]              total_reg, total_next;
    logic                       req_reg, req_next;
    logic [SFS_DELTA_BITS-1:0]  delta_reg, delta_next;
    logic [SFS_IDX_BITS-1:0]    idx_reg, idx_next;
    logic [SFS_GEOM_BITS-1:0]   fw_reg, fw_next;
    logic [SFS_GEOM_BITS-1:0]   fh_reg, fh_next;
    logic [SFS_IDX_BITS-1:0]    row_reg, row_next;
    logic [SFS_CELL_BITS-1:0]   col_reg, col_next;
    logic [SFS_GEOM_BITS-1:0]   left_reg, left_next;
    logic [SFS_GEOM_BITS-1:0]   bottom_reg, bottom_next;
    logic                       end_ev_reg, end_ev_next;

    // Output register
    logic                         out_valid_reg, out_valid_next;
    logic [SFS_OUT_DATA_BITS-1:0] out_data_reg, out_data_next;
    logic [SFS_OUT_USER_BITS-1:0] out_user_reg, out_user_next;

    ucode_t                    ctl;
    logic [SFS_CNT_BITS-1:0]   a_eff, d_eff;
    logic [SFS_DUR_BITS-1:0]   dur_eff;
    logic [SFS_GEOM_BITS-1:0]  sw_eff, sh_eff;
    logic [2*SFS_CNT_BITS-1:0] frames_prod;
    logic [TIME_BITS:0]        sum_w;
    logic [TIME_BITS-1:0]      sat_w;
    logic [SFS_CELL_BITS-1:0]  d_m1, row_c, row_sel;
    logic                      cond_hit;
    logic                      advance;
    logic                      in_fire;
    logic                      out_free;

    logic                      div_start;
    logic [CNT_W-1:0]          div_count;
    logic [RW-1:0]             div_rem_init;
    logic [TIME_BITS-1:0]      div_quo_init;
    logic [RW-1:0]             div_divisor;
    logic                      div_busy;
    logic [RW-1:0]             div_rem;
    logic [TIME_BITS-1:0]      div_quo;

    assign ctl = sfs_ucode(pc_reg);

    // Effective register values
    assign a_eff   = sfs_clamp_cnt(across_reg);
    assign d_eff   = sfs_clamp_cnt(down_reg);
    assign dur_eff = (dur_reg == '0) ? SFS_DUR_BITS'(1) : dur_reg;
    assign sw_eff  = sfs_clamp_sheet(sw_reg);
    assign sh_eff  = sfs_clamp_sheet(sh_reg);

    // Frame count, registered before it feeds the wrap period multiplier
    assign frames_prod = a_eff * d_eff;
    assign frames_next = (frames_prod > (2*SFS_CNT_BITS)'(SFS_MAX_FRAMES)) ?
                         SFS_MAX_FRAMES : SFS_FRAMES_BITS'(frames_prod);

    // Saturating time add
    assign sum_w = {1'b0, elapsed_reg} + (TIME_BITS + 1)'(delta_reg);
    assign sat_w = sum_w[TIME_BITS] ? '1 : sum_w[TIME_BITS-1:0];

    // Row selection for the bottom edge
    assign d_m1    = SFS_CELL_BITS'(d_eff - 5'd1);
    assign row_c   = (row_reg >= SFS_IDX_BITS'(d_eff)) ? d_m1 : row_reg[SFS_CELL_BITS-1:0];
    assign row_sel = ttb_reg ? SFS_CELL_BITS'(d_m1 - row_c) : row_c;

    // Handshakes
    assign s_tready  = (ctl.op == OP_ACCEPT);
    assign in_fire   = s_tvalid & s_tready;
    assign out_free  = ~out_valid_reg | m_tready;
    assign cfg_ready = 1'b1;

    // Jump condition
    always_comb
    begin
        unique case (ctl.cond)
            COND_NEVER:   cond_hit = 1'b0;
            COND_ALWAYS:  cond_hit = 1'b1;
            COND_RESTART: cond_hit = (req_reg == SFS_REQ_RESTART);
            COND_STOPPED: cond_hit = ~playing_reg;
            default:      cond_hit = 1'b0;
        endcase
    end

    // Step holds on an empty input, a busy divider or a full output register
    always_comb
    begin
        unique case (ctl.op)
            OP_ACCEPT:   advance = in_fire;
            OP_DIV_WAIT: advance = ~div_busy;
            OP_EMIT:     advance = out_free;
            default:     advance = 1'b1;
        endcase
    end

    assign pc_next = !advance ? pc_reg :
                     cond_hit ? ctl.target : pc_reg + SFS_PC_BITS'(1);

    // Divider operand selection
    assign div_start = (ctl.op == OP_DIV_START);
    always_comb
    begin
        div_rem_init = '0;
        div_quo_init = elapsed_reg;
        div_divisor  = total_reg;
        div_count    = CNT_W'(TIME_BITS);
        unique case (ctl.dsel)
            DSEL_MOD:
            begin
                div_rem_init = '0;
                div_quo_init = elapsed_reg;
                div_divisor  = total_reg;
                div_count    = CNT_W'(TIME_BITS);
            end
            DSEL_IDX:
            begin
                // quotient stays below 2^8, so the top part already sits below the divisor
                div_rem_init = RW'(elapsed_reg >> SFS_IDX_BITS);
                div_quo_init = {elapsed_reg[SFS_IDX_BITS-1:0],
                                {(TIME_BITS-SFS_IDX_BITS){1'b0}}};
                div_divisor  = RW'(dur_eff);
                div_count    = CNT_W'(SFS_IDX_BITS);
            end
            DSEL_FW:
            begin
                div_rem_init = '0;
                div_quo_init = {sw_eff, {(TIME_BITS-SFS_GEOM_BITS){1'b0}}};
                div_divisor  = RW'(a_eff);
                div_count    = CNT_W'(SFS_GEOM_BITS);
            end
            DSEL_FH:
            begin
                div_rem_init = '0;
                div_quo_init = {sh_eff, {(TIME_BITS-SFS_GEOM_BITS){1'b0}}};
                div_divisor  = RW'(d_eff);
                div_count    = CNT_W'(SFS_GEOM_BITS);
            end
            DSEL_CR:
            begin
                div_rem_init = '0;
                div_quo_init = {shown_reg, {(TIME_BITS-SFS_IDX_BITS){1'b0}}};
                div_divisor  = RW'(a_eff);
                div_count    = CNT_W'(SFS_IDX_BITS);
            end
            default:
            begin
                div_rem_init = '0;
            end
        endcase
    end

    sfs_divider #(
        .DW (TIME_BITS),
        .CW (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .count    (div_count),
        .rem_init (div_rem_init),
        .quo_init (div_quo_init),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .rem      (div_rem),
        .quo      (div_quo)
    );

    // Datapath controlled by the current control word
    always_comb
    begin
        across_next    = across_reg;
        down_next      = down_reg;
        dur_next       = dur_reg;
        sw_next        = sw_reg;
        sh_next        = sh_reg;
        ttb_next       = ttb_reg;
        loop_next      = loop_reg;
        hold_next      = hold_reg;
        elapsed_next   = elapsed_reg;
        shown_next     = shown_reg;
        playing_next   = playing_reg;
        holding_next   = holding_reg;
        total_next     = total_reg;
        req_next       = req_reg;
        delta_next     = delta_reg;
        idx_next       = idx_reg;
        fw_next        = fw_reg;
        fh_next        = fh_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        left_next      = left_reg;
        bottom_next    = bottom_reg;
        end_ev_next    = end_ev_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_valid_next = out_valid_reg & ~m_tready;

        unique case (ctl.op)
            OP_ACCEPT:
            begin
                if (in_fire)
                begin
                    req_next    = s_tuser;
                    delta_next  = s_tdata[SFS_DELTA_BITS-1:0];
                    end_ev_next = 1'b0;
                end
            end
            OP_RESTART:
            begin
                elapsed_next = '0;
                playing_next = 1'b1;
                holding_next = 1'b0;
                shown_next   = '0;
            end
            OP_TOTAL_SUM:
            begin
                total_next   = RW'(frames_reg * dur_eff);
                elapsed_next = sat_w;
            end
            OP_SATADD:
            begin
                elapsed_next = sat_w;
            end
            OP_DIV_WAIT:
            begin
                if (!div_busy)
                begin
                    case (ctl.dsel)
                        DSEL_MOD: elapsed_next = TIME_BITS'(div_rem);
                        DSEL_IDX: idx_next = div_quo[SFS_IDX_BITS-1:0];
                        DSEL_FW:  fw_next = div_quo[SFS_GEOM_BITS-1:0];
                        DSEL_FH:  fh_next = div_quo[SFS_GEOM_BITS-1:0];
                        DSEL_CR:
                        begin
                            row_next = div_quo[SFS_IDX_BITS-1:0];
                            col_next = div_rem[SFS_CELL_BITS-1:0];
                        end
                        default: idx_next = idx_reg;
                    endcase
                end
            end
            OP_UPDATE:
            begin
                // back at frame 0 without looping ends the run
                if (idx_reg != shown_reg)
                begin
                    if (idx_reg == '0 && !loop_reg)
                    begin
                        end_ev_next = ~holding_reg;
                        if (hold_reg)
                            holding_next = 1'b1;
                        else
                            playing_next = 1'b0;
                    end
                    else if (!holding_reg)
                    begin
                        shown_next = idx_reg;
                    end
                end
            end
            OP_CLAMP:
            begin
                if (SFS_FRAMES_BITS'(shown_reg) >= frames_reg)
                    shown_next = '0;
            end
            OP_MUL:
            begin
                left_next   = SFS_GEOM_BITS'(col_reg * fw_reg);
                bottom_next = SFS_GEOM_BITS'(row_sel * fh_reg);
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, fh_reg, fw_reg,
                                      SFS_GEOM_BITS'(bottom_reg + fh_reg),
                                      SFS_GEOM_BITS'(left_reg + fw_reg),
                                      bottom_reg, left_reg, shown_reg};
                    out_user_next  = {end_ev_reg, playing_reg};
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase

        // Register writes must arrive only while the sequencer is idle; the block does not check
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_ACROSS:
                begin
                    across_next = cfg_data[SFS_CNT_BITS-1:0];
                    shown_next  = '0;
                end
                CFG_DOWN:
                begin
                    down_next  = cfg_data[SFS_CNT_BITS-1:0];
                    shown_next = '0;
                end
                CFG_DURATION:
                begin
                    dur_next   = cfg_data[SFS_DUR_BITS-1:0];
                    shown_next = '0;
                end
                CFG_SHEET_W:
                begin
                    sw_next    = cfg_data[SFS_GEOM_BITS-1:0];
                    shown_next = '0;
                end
                CFG_SHEET_H:
                begin
                    sh_next    = cfg_data[SFS_GEOM_BITS-1:0];
                    shown_next = '0;
                end
                CFG_TTB:
                begin
                    ttb_next   = cfg_data[0];
                    shown_next = '0;
                end
                CFG_LOOPING: loop_next = cfg_data[0];
                CFG_HOLD:    hold_next = cfg_data[0];
                default:     loop_next = loop_reg;
            endcase
        end
    end

    // Control and animation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ST_IDLE;
            across_reg    <= SFS_RST_ACROSS;
            down_reg      <= SFS_RST_DOWN;
            dur_reg       <= SFS_RST_DUR;
            sw_reg        <= SFS_RST_SHEET;
            sh_reg        <= SFS_RST_SHEET;
            ttb_reg       <= 1'b0;
            loop_reg      <= 1'b0;
            hold_reg      <= 1'b0;
            elapsed_reg   <= '0;
            shown_reg     <= '0;
            playing_reg   <= 1'b1;
            holding_reg   <= 1'b0;
            frames_reg    <= SFS_FRAMES_BITS'(1);
            end_ev_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            across_reg    <= across_next;
            down_reg      <= down_next;
            dur_reg       <= dur_next;
            sw_reg        <= sw_next;
            sh_reg        <= sh_next;
            ttb_reg       <= ttb_next;
            loop_reg      <= loop_next;
            hold_reg      <= hold_next;
            elapsed_reg   <= elapsed_next;
            shown_reg     <= shown_next;
            playing_reg   <= playing_next;
            holding_reg   <= holding_next;
            frames_reg    <= frames_next;
            end_ev_reg    <= end_ev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        total_reg    <= total_next;
        req_reg      <= req_next;
        delta_reg    <= delta_next;
        idx_reg      <= idx_next;
        fw_reg       <= fw_next;
        fh_reg       <= fh_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        left_reg     <= left_next;
        bottom_reg   <= bottom_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ----- tb/sfs_checker.sv -----
// Watches the request, register and result channels of the sequencer, keeps its
// own copy of the animation state and compares every result field by field.
module sfs_checker #(
    parameter int TIME_BITS = sfs_pkg::SFS_DEF_TIME_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    input  logic                                   s_tready,
    input  logic [sfs_pkg::SFS_IN_DATA_BITS-1:0]   s_tdata,  // [19:0] time_delta
    input  logic                                   s_tuser,  // [0] req_type
    input  logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [7:0] frame_index, [20:8] rect_left, [33:21] rect_bottom, [46:34] rect_right,
    // [59:47] rect_top, [72:60] frame_width, [85:73] frame_height
    input  logic [sfs_pkg::SFS_OUT_DATA_BITS-1:0]  m_tdata,
    input  logic [sfs_pkg::SFS_OUT_USER_BITS-1:0]  m_tuser,  // [0] playing, [1] end_event
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [sfs_pkg::SFS_CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [sfs_pkg::SFS_CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                   end_of_run,
    output int                                     errors,
    output int                                     pending,
    output int                                     results_seen,
    output int                                     end_events,
    output int                                     stopped_results
);
    import sfs_pkg::*;

    localparam longint unsigned ELAPSED_MAX = (64'd1 << TIME_BITS) - 64'd1;
    localparam int              SHOWN_LINES = 60;

    // One result, laid out as {m_tuser, m_tdata[85:0]}
    typedef struct packed {
        logic                     end_event;
        logic                     playing;
        logic [SFS_GEOM_BITS-1:0] frame_height;
        logic [SFS_GEOM_BITS-1:0] frame_width;
        logic [SFS_GEOM_BITS-1:0] rect_top;
        logic [SFS_GEOM_BITS-1:0] rect_right;
        logic [SFS_GEOM_BITS-1:0] rect_bottom;
        logic [SFS_GEOM_BITS-1:0] rect_left;
        logic [SFS_IDX_BITS-1:0]  frame_index;
    } sprite_view_t;

    localparam int VIEW_DATA_BITS = $bits(sprite_view_t) - SFS_OUT_USER_BITS;

    // Register copies
    logic [SFS_CNT_BITS-1:0]  across_r;
    logic [SFS_CNT_BITS-1:0]  down_r;
    logic [SFS_DUR_BITS-1:0]  dur_r;
    logic [SFS_GEOM_BITS-1:0] sheet_w_r;
    logic [SFS_GEOM_BITS-1:0] sheet_h_r;
    logic                     ttb_r;
    logic                     loop_r;
    logic                     hold_r;

    // Animation state
    longint unsigned          elapsed_us;
    logic [SFS_IDX_BITS-1:0]  shown_frame;
    logic                     is_playing;
    logic                     is_holding;

    sprite_view_t             expected_frames[$];
    sprite_view_t             got;
    sprite_view_t             want;

    initial
    begin
        errors          = 0;
        pending         = 0;
        results_seen    = 0;
        end_events      = 0;
        stopped_results = 0;
    end

    function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic report_fault(input string msg);
        errors++;
        if (errors <= SHOWN_LINES)
            $display("[%0t] sprite check: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input longint unsigned g,
                               input longint unsigned w);
        if (g != w)
            report_fault($sformatf("result %0d: %s is %0d, expected %0d",
                                   results_seen, name, g, w));
    endtask

    // Applies one request to the animation state and works out the frame shown
    task automatic advance_sprite(input logic kind, input logic [SFS_DELTA_BITS-1:0] delta,
                                  output sprite_view_t v);
        int unsigned     a;
        int unsigned     d;
        int unsigned     n;
        int unsigned     idx;
        int unsigned     fw;
        int unsigned     fh;
        int unsigned     col;
        int unsigned     row;
        int unsigned     left;
        int unsigned     bottom;
        longint unsigned dur;
        longint unsigned acc_us;
        logic            end_ev;

        end_ev = 1'b0;
        a = clamp_u(across_r, 1, SFS_CNT_MAX);
        d = clamp_u(down_r, 1, SFS_CNT_MAX);
        n = clamp_u(a * d, 1, SFS_MAX_FRAMES);

        acc_us = elapsed_us + delta;
        if (acc_us > ELAPSED_MAX)
            acc_us = ELAPSED_MAX;

        if (kind == SFS_REQ_RESTART)
        begin
            elapsed_us  = 0;
            is_playing  = 1'b1;
            is_holding  = 1'b0;
            shown_frame = '0;
        end
        else if (is_playing)
        begin
            dur = (dur_r == '0) ? 1 : dur_r;
            elapsed_us = acc_us % (n * dur);
            idx = elapsed_us / dur;
            if (idx != shown_frame)
            begin
                // back at frame 0 without looping: the run is over
                if (idx == 0 && !loop_r)
                begin
                    end_ev = !is_holding;
                    if (hold_r)
                        is_holding = 1'b1;
                    else
                        is_playing = 1'b0;
                end
                else if (!is_holding)
                    shown_frame = idx;
            end
        end
        else
            elapsed_us = acc_us;

        if (shown_frame >= n)
            shown_frame = '0;

        // Sheet rectangle of the shown frame
        fw  = clamp_u(sheet_w_r, 1, SFS_SHEET_MAX) / a;
        fh  = clamp_u(sheet_h_r, 1, SFS_SHEET_MAX) / d;
        col = shown_frame % a;
        row = shown_frame / a;
        if (row >= d)
            row = d - 1;
        left   = col * fw;
        bottom = ttb_r ? (d - row - 1) * fh : row * fh;

        v.frame_index  = shown_frame;
        v.rect_left    = left;
        v.rect_bottom  = bottom;
        v.rect_right   = left + fw;
        v.rect_top     = bottom + fh;
        v.frame_width  = fw;
        v.frame_height = fh;
        v.playing      = is_playing;
        v.end_event    = end_ev;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            across_r    = SFS_RST_ACROSS;
            down_r      = SFS_RST_DOWN;
            dur_r       = SFS_RST_DUR;
            sheet_w_r   = SFS_RST_SHEET;
            sheet_h_r   = SFS_RST_SHEET;
            ttb_r       = 1'b0;
            loop_r      = 1'b0;
            hold_r      = 1'b0;
            elapsed_us  = 0;
            shown_frame = '0;
            is_playing  = 1'b1;
            is_holding  = 1'b0;
            expected_frames.delete();
            pending = 0;
        end
        else
        begin
            // Results first, so a request taken on the same edge is not matched
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_frames.size() == 0)
                    report_fault($sformatf("result %0d arrived with no frame expected",
                                           results_seen));
                else
                begin
                    want = expected_frames.pop_front();
                    got  = sprite_view_t'({m_tuser, m_tdata[VIEW_DATA_BITS-1:0]});
                    check_field("frame_index", got.frame_index, want.frame_index);
                    check_field("rect_left", got.rect_left, want.rect_left);
                    check_field("rect_bottom", got.rect_bottom, want.rect_bottom);
                    check_field("rect_right", got.rect_right, want.rect_right);
                    check_field("rect_top", got.rect_top, want.rect_top);
                    check_field("frame_width", got.frame_width, want.frame_width);
                    check_field("frame_height", got.frame_height, want.frame_height);
                    check_field("playing", got.playing, want.playing);
                    check_field("end_event", got.end_event, want.end_event);
                    check_field("tdata padding", m_tdata[SFS_OUT_DATA_BITS-1:VIEW_DATA_BITS], 0);
                    if (want.end_event)
                        end_events++;
                    if (!want.playing)
                        stopped_results++;
                end
            end

            // Register writes; any register but looping and hold sends the display back to frame 0
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_ACROSS:   across_r  = cfg_data[SFS_CNT_BITS-1:0];
                    CFG_DOWN:     down_r    = cfg_data[SFS_CNT_BITS-1:0];
                    CFG_DURATION: dur_r     = cfg_data[SFS_DUR_BITS-1:0];
                    CFG_SHEET_W:  sheet_w_r = cfg_data[SFS_GEOM_BITS-1:0];
                    CFG_SHEET_H:  sheet_h_r = cfg_data[SFS_GEOM_BITS-1:0];
                    CFG_TTB:      ttb_r     = cfg_data[0];
                    CFG_LOOPING:  loop_r    = cfg_data[0];
                    CFG_HOLD:     hold_r    = cfg_data[0];
                    default: ;
                endcase
                if (cfg_addr <= CFG_TTB)
                    shown_frame = '0;
            end

            if (s_tvalid && s_tready)
            begin
                advance_sprite(s_tuser, s_tdata[SFS_DELTA_BITS-1:0], want);
                expected_frames.push_back(want);
            end

            pending = expected_frames.size();
        end
    end

    // Anything still queued once the run has drained is a missing result
    always @(posedge end_of_run)
    begin
        if (expected_frames.size() != 0)
            report_fault($sformatf("%0d frames still expected at end of run",
                                   expected_frames.size()));
    end

endmodule

// ----- tb/sprite_frame_sequencer_core_tb.sv -----
// Stimulus and verdict for the sprite frame sequencer; checking lives in sfs_checker.
module sprite_frame_sequencer_core_tb;
    import sfs_pkg::*;

    localparam int RANDOM_REQS   = 1850;
    localparam int SETTLE_CYCLES = 120;
    localparam int MAX_GAP       = 160;
    localparam int MAX_STALL     = 150;
    localparam int MAX_DELTA     = 20'hFFFFF;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [SFS_IN_DATA_BITS-1:0]   s_tdata;   // [19:0] time_delta
    logic                          s_tuser;   // [0] req_type
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // [7:0] frame_index, [20:8] rect_left, [33:21] rect_bottom, [46:34] rect_right,
    // [59:47] rect_top, [72:60] frame_width, [85:73] frame_height
    logic [SFS_OUT_DATA_BITS-1:0]  m_tdata;
    logic [SFS_OUT_USER_BITS-1:0]  m_tuser;   // [0] playing, [1] end_event
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [SFS_CFG_ADDR_BITS-1:0]  cfg_addr;
    logic [SFS_CFG_DATA_BITS-1:0]  cfg_data;
    logic                          end_of_run;

    int                            errors;
    int                            pending;
    int                            results_seen;
    int                            end_events;
    int                            stopped_results;

    int                            burst_left  = 0;
    int                            reqs_sent   = 0;
    int                            settings    = 0;
    logic [SFS_DUR_BITS-1:0]       cur_duration;

    int                            stall_mode  = 0;
    int                            mode_left   = 0;
    int                            run_left    = 0;

    always #5 clk = ~clk;

    sprite_frame_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    sfs_checker u_sprite_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .end_of_run      (end_of_run),
        .errors          (errors),
        .pending         (pending),
        .results_seen    (results_seen),
        .end_events      (end_events),
        .stopped_results (stopped_results)
    );

    // Result side: the stall pattern switches at random between four modes
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 600);
        end
        mode_left--;
        case (stall_mode)
            0: m_tready = 1'b1;
            1: m_tready = ($urandom_range(0, 3) != 0);
            2: m_tready = ($urandom_range(0, 3) == 0);
            default:
            begin
                // long runs of ready and not ready
                if (run_left == 0)
                begin
                    m_tready = !m_tready;
                    run_left = $urandom_range(1, MAX_STALL);
                end
                else
                    run_left--;
            end
        endcase
    end

    // One request, sent in bursts with random gaps between them; called at a falling edge
    task automatic send_req(input logic kind, input logic [SFS_DELTA_BITS-1:0] delta);
        int gap;

        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap != 0)
            begin
                s_tvalid = 1'b0;
                s_tdata  = $urandom;
                s_tuser  = $urandom_range(0, 1);
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {{(SFS_IN_DATA_BITS - SFS_DELTA_BITS){1'b0}}, delta};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        reqs_sent++;
    endtask

    // Hold off new requests until every result is back, then let the block settle
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [SFS_CFG_DATA_BITS-1:0] val);
        cfg_valid = 1'b1;
        cfg_addr  = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == CFG_DURATION)
            cur_duration = val;
    endtask

    // Full register set in a rotated order, with junk above each register's width
    task automatic load_sheet(input logic [SFS_CNT_BITS-1:0] across,
                              input logic [SFS_CNT_BITS-1:0] down,
                              input logic [SFS_DUR_BITS-1:0] dur,
                              input logic [SFS_GEOM_BITS-1:0] sw,
                              input logic [SFS_GEOM_BITS-1:0] sh,
                              input logic ttb, input logic looping, input logic hold);
        int                           start;
        cfg_idx_t                     idx;
        logic [SFS_CFG_DATA_BITS-1:0] junk;
        logic [SFS_CFG_DATA_BITS-1:0] val;

        start = $urandom_range(0, 7);
        for (int k = 0; k < 8; k++)
        begin
            idx  = cfg_idx_t'((start + k) % 8);
            junk = $urandom;
            case (idx)
                CFG_ACROSS:   val = {junk[23:SFS_CNT_BITS], across};
                CFG_DOWN:     val = {junk[23:SFS_CNT_BITS], down};
                CFG_DURATION: val = dur;
                CFG_SHEET_W:  val = {junk[23:SFS_GEOM_BITS], sw};
                CFG_SHEET_H:  val = {junk[23:SFS_GEOM_BITS], sh};
                CFG_TTB:      val = {junk[23:1], ttb};
                CFG_LOOPING:  val = {junk[23:1], looping};
                default:      val = {junk[23:1], hold};
            endcase
            write_reg(idx, val);
        end
        settings++;
    endtask

    initial
    begin
        logic [SFS_CNT_BITS-1:0]  r_across;
        logic [SFS_CNT_BITS-1:0]  r_down;
        logic [SFS_DUR_BITS-1:0]  r_dur;
        logic [SFS_GEOM_BITS-1:0] r_sw;
        logic [SFS_GEOM_BITS-1:0] r_sh;
        int                       random_sent;
        int                       phase_no;
        int                       phase_len;
        int                       pick;
        int unsigned              dur_e;
        int unsigned              delta_us;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = SFS_REQ_TICK;
        cfg_valid    = 1'b0;
        cfg_addr     = CFG_ACROSS;
        cfg_data     = '0;
        end_of_run   = 1'b0;
        cur_duration = SFS_RST_DUR;
        random_sent  = 0;
        phase_no     = 0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: a single frame, so the display never moves
        send_req(SFS_REQ_TICK, 0);
        send_req(SFS_REQ_TICK, MAX_DELTA);
        send_req(SFS_REQ_RESTART, MAX_DELTA);
        drain();

        // 4x2 sheet, step through every frame, end, tick while stopped, restart
        load_sheet(4, 2, 10, 64, 32, 1'b0, 1'b0, 1'b0);
        for (int i = 0; i < 8; i++)
            send_req(SFS_REQ_TICK, 10);
        send_req(SFS_REQ_TICK, 5);
        send_req(SFS_REQ_RESTART, 20'hABCDE);
        drain();

        // Out-of-range registers, rows from the top, holding the last frame
        load_sheet(31, 0, 0, 13'h1FFF, 0, 1'b1, 1'b0, 1'b1);
        send_req(SFS_REQ_TICK, 15);
        send_req(SFS_REQ_TICK, 1);
        send_req(SFS_REQ_TICK, 3);
        send_req(SFS_REQ_TICK, 13);
        drain();

        // Frame count capped at its maximum, looping through the wrap
        load_sheet(16, 31, 1, 4096, 4096, 1'b1, 1'b1, 1'b0);
        send_req(SFS_REQ_TICK, 255);
        send_req(SFS_REQ_TICK, 1);
        send_req(SFS_REQ_TICK, MAX_DELTA);
        drain();

        // Random phases: fresh settings, or a few single writes over the running state
        while (random_sent < RANDOM_REQS)
        begin
            if (phase_no % 3 == 2)
            begin
                repeat ($urandom_range(1, 3))
                    write_reg(cfg_idx_t'($urandom_range(0, 7)), $urandom);
                settings++;
            end
            else
            begin
                r_across = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(1, 4);
                r_down   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(1, 4);
                case ($urandom_range(0, 5))
                    0:       r_dur = 0;
                    1:       r_dur = $urandom_range(1, 16);
                    2:       r_dur = $urandom_range(17, 4096);
                    3:       r_dur = $urandom_range(4097, 200000);
                    4:       r_dur = $urandom_range(200001, 24'hFFFFFF);
                    default: r_dur = 24'hFFFFFF;
                endcase
                case ($urandom_range(0, 3))
                    0:       r_sw = $urandom_range(0, 8191);
                    1:       r_sw = $urandom_range(4096, 8191);
                    default: r_sw = $urandom_range(1, 4096);
                endcase
                case ($urandom_range(0, 3))
                    0:       r_sh = $urandom_range(0, 8191);
                    1:       r_sh = $urandom_range(4096, 8191);
                    default: r_sh = $urandom_range(1, 4096);
                endcase
                load_sheet(r_across, r_down, r_dur, r_sw, r_sh, $urandom_range(0, 1),
                           $urandom_range(0, 2) == 0, $urandom_range(0, 1));
            end
            phase_no++;

            phase_len = $urandom_range(60, 250);
            repeat (phase_len)
            begin
                pick  = $urandom_range(0, 19);
                dur_e = (cur_duration == '0) ? 1 : cur_duration;
                // mostly ticks of about one or two frames, so runs reach their end
                case (pick)
                    1:       delta_us = 0;
                    2:       delta_us = MAX_DELTA;
                    3, 4:    delta_us = $urandom_range(0, MAX_DELTA);
                    5:       delta_us = $urandom_range(0, dur_e / 2);
                    default: delta_us = dur_e * $urandom_range(1, 2)
                                        + $urandom_range(0, dur_e / 4);
                endcase
                if (delta_us > MAX_DELTA)
                    delta_us = MAX_DELTA - $urandom_range(0, 255);
                if (pick == 0)
                    send_req(SFS_REQ_RESTART, $urandom);
                else
                    send_req(SFS_REQ_TICK, delta_us);
                random_sent++;
                if ($urandom_range(0, 149) == 0)
                    drain();
            end
            drain();
        end

        end_of_run = 1'b1;
        @(negedge clk);

        $display("Run covered %0d requests (%0d random) over %0d register settings.",
                 reqs_sent, random_sent, settings);
        $display("%0d results compared: %0d end events, %0d while stopped.",
                 results_seen, end_events, stopped_results);
        if (errors == 0)
            $display("PASS sprite_frame_sequencer_core");
        else
            $display("FAIL sprite_frame_sequencer_core");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial
    begin
        #60000000;
        $display("Timed out with %0d results still expected", pending);
        $display("FAIL sprite_frame_sequencer_core");
        $finish;
    end

endmodule

// ----- sim.f -----
design/sfs_pkg.sv
design/sfs_divider.sv
design/sprite_frame_sequencer_core.sv
tb/sfs_checker.sv
tb/sprite_frame_sequencer_core_tb.sv
